[rtl/mf2d_pkg.sv]
// Shared types, constants and helpers for the 2-D median filter.
// Used by every module of the block but mf2d_ram; depends on nothing.
package mf2d_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HALF   = 3;
  localparam int PIXEL_BITS = 8;
  localparam int MIN_SIZE   = 8;
  localparam int HEIGHT_CAP = 1024;

  localparam int STORE_ROWS = 2 * MAX_HALF + 1;
  localparam int WIN_N      = STORE_ROWS * STORE_ROWS;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int DIM_W      = 11;
  localparam int ROW_W      = 10;
  localparam int HALF_W     = 2;
  localparam int PHYS_W     = $clog2(STORE_ROWS);
  localparam int SIDE_W     = $clog2(STORE_ROWS + 1);
  localparam int RANK_W     = $clog2(WIN_N + 1);
  localparam int BIT_W      = $clog2(PIXEL_BITS);
  localparam int QDEPTH     = 4;
  localparam int QPTR_W     = $clog2(QDEPTH);
  localparam int ADDR_W     = 4;
  localparam int DATA_W     = 32;

  localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd1;
  localparam logic [1:0] REG_KERNEL_HALF  = 2'd2;

  typedef struct packed {
    logic                  cmd;
    logic [PIXEL_BITS-1:0] pixel;
  } in_item_t;

  typedef struct packed {
    logic [PIXEL_BITS-1:0] median;
    logic                  last_in_row;
    logic                  last_in_frame;
  } out_item_t;

  typedef struct packed {
    logic [DIM_W-1:0]  width;
    logic [DIM_W-1:0]  height;
    logic [HALF_W-1:0] half;
  } cfg_t;

  // One output pixel to compute: its position, the input row that issued it
  // and the line-store row that holds its center row.
  typedef struct packed {
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic [DIM_W-1:0]  irow;
    logic [PHYS_W-1:0] prow;
  } job_t;

  typedef struct packed {
    logic                  we;
    logic [PHYS_W-1:0]     row;
    logic [COL_W-1:0]      col;
    logic [PIXEL_BITS-1:0] data;
  } wr_t;

  // Rank of the median inside a window of side 2k+1.
  function automatic logic [RANK_W-1:0] half_rank(input logic [HALF_W-1:0] k);
    logic [RANK_W-1:0] r;
    case (k)
      2'd1:    r = RANK_W'(4);
      2'd2:    r = RANK_W'(12);
      default: r = RANK_W'(24);
    endcase
    return r;
  endfunction

endpackage

[rtl/mf2d_ram.sv]
// Generic simple dual-port RAM with one write port and a registered read.
// Stand-alone; no package needed.
module mf2d_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/mf2d_queue.sv]
// Short job queue between the front and back parts of the median filter.
// Depends on mf2d_pkg; shows all entries so the front can check store hazards.
module mf2d_queue (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                push_i,
  input  mf2d_pkg::job_t                      job_i,
  input  logic                                pop_i,
  output mf2d_pkg::job_t                      job_o,
  output logic                                full_o,
  output logic                                empty_o,
  output mf2d_pkg::job_t [mf2d_pkg::QDEPTH-1:0] ent_o,
  output logic [mf2d_pkg::QDEPTH-1:0]         vld_o
);

  mf2d_pkg::job_t [mf2d_pkg::QDEPTH-1:0] ent_q;
  logic [mf2d_pkg::QPTR_W-1:0] wr_q, rd_q;
  logic [mf2d_pkg::QPTR_W:0]   cnt_q;

  assign full_o  = cnt_q == (mf2d_pkg::QPTR_W+1)'(mf2d_pkg::QDEPTH);
  assign empty_o = cnt_q == '0;
  assign job_o   = ent_q[rd_q];
  assign ent_o   = ent_q;

  always_comb begin
    logic [mf2d_pkg::QPTR_W-1:0] off;
    vld_o = '0;
    for (int i = 0; i < mf2d_pkg::QDEPTH; i++) begin
      off      = mf2d_pkg::QPTR_W'(i) - rd_q;
      vld_o[i] = {1'b0, off} < cnt_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wr_q] <= job_i;
    end
  end

endmodule

[rtl/mf2d_front.sv]
// Front part: tracks the input position, writes the line store and posts jobs.
// Depends on mf2d_pkg.
module mf2d_front (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  mf2d_pkg::cfg_t                        cfg_i,
  input  logic                                  restart_i,
  input  logic                                  in_valid_i,
  input  mf2d_pkg::in_item_t                    in_data_i,
  output logic                                  in_stall_o,
  output mf2d_pkg::wr_t                         wr_o,
  output logic                                  push_o,
  output mf2d_pkg::job_t                        job_o,
  input  logic                                  q_full_i,
  input  mf2d_pkg::job_t [mf2d_pkg::QDEPTH-1:0] q_ent_i,
  input  logic [mf2d_pkg::QDEPTH-1:0]           q_vld_i,
  input  logic                                  bk_busy_i,
  input  mf2d_pkg::job_t                        bk_job_i
);

  logic [mf2d_pkg::DIM_W-1:0]  ir_q, ir_d, eir, irn;
  logic [mf2d_pkg::COL_W-1:0]  ic_q, ic_d, eic;
  logic [mf2d_pkg::PHYS_W-1:0] p_q, p_d, ep, pr;
  logic [mf2d_pkg::SIDE_W-1:0] bl_q, bl_d, nj;
  mf2d_pkg::job_t              bjob_q, bjob_d;
  logic [mf2d_pkg::DIM_W:0]    hk, icn;
  logic [mf2d_pkg::COL_W-1:0]  c0;
  logic wrap, writes, hazard, acc, emits, last_col;

  assign hk   = {1'b0, cfg_i.height} + (mf2d_pkg::DIM_W+1)'(cfg_i.half);
  assign wrap = ({1'b0, ir_q} >= hk) || ({2'b0, ic_q} >= {1'b0, cfg_i.width});
  assign eir  = wrap ? '0 : ir_q;
  assign eic  = wrap ? '0 : ic_q;
  assign ep   = wrap ? '0 : p_q;

  assign writes = eir < cfg_i.height;

  // An item that writes may overwrite a store row that a pending job of an
  // older input row still reads, so it waits until those jobs are done.
  always_comb begin
    hazard = bk_busy_i && (bk_job_i.irow != eir);
    if (bl_q != '0 && bjob_q.irow != eir) begin
      hazard = 1'b1;
    end
    for (int i = 0; i < mf2d_pkg::QDEPTH; i++) begin
      if (q_vld_i[i] && q_ent_i[i].irow != eir) begin
        hazard = 1'b1;
      end
    end
    hazard = hazard && writes;
  end

  assign push_o     = (bl_q != '0) && !q_full_i;
  assign job_o      = bjob_q;
  assign in_stall_o = hazard || ((bl_q != '0) && !((bl_q == mf2d_pkg::SIDE_W'(1)) && push_o));
  assign acc        = in_valid_i && !in_stall_o;

  assign wr_o.we   = acc && writes;
  assign wr_o.row  = ep;
  assign wr_o.col  = eic;
  assign wr_o.data = in_data_i.cmd ? '0 : in_data_i.pixel;

  // Jobs of one item form a run of consecutive columns of row eir-k.
  always_comb begin
    emits    = eir >= mf2d_pkg::DIM_W'(cfg_i.half);
    last_col = {1'b0, eic} == (cfg_i.width - mf2d_pkg::DIM_W'(1));
    if (last_col) begin
      c0 = mf2d_pkg::COL_W'(cfg_i.width - mf2d_pkg::DIM_W'(1)
                            - mf2d_pkg::DIM_W'(cfg_i.half));
      nj = mf2d_pkg::SIDE_W'(cfg_i.half) + mf2d_pkg::SIDE_W'(1);
    end else if (eic >= mf2d_pkg::COL_W'(cfg_i.half)) begin
      c0 = eic - mf2d_pkg::COL_W'(cfg_i.half);
      nj = mf2d_pkg::SIDE_W'(1);
    end else begin
      c0 = eic;
      nj = '0;
    end
    if ({1'b0, ep} >= (mf2d_pkg::PHYS_W+1)'(cfg_i.half)) begin
      pr = ep - mf2d_pkg::PHYS_W'(cfg_i.half);
    end else begin
      pr = mf2d_pkg::PHYS_W'({1'b0, ep} + (mf2d_pkg::PHYS_W+1)'(mf2d_pkg::STORE_ROWS)
                             - (mf2d_pkg::PHYS_W+1)'(cfg_i.half));
    end
  end

  always_comb begin
    bl_d   = bl_q;
    bjob_d = bjob_q;
    ir_d   = ir_q;
    ic_d   = ic_q;
    p_d    = p_q;
    icn    = {2'b0, eic} + (mf2d_pkg::DIM_W+1)'(1);
    irn    = eir + mf2d_pkg::DIM_W'(1);
    if (push_o) begin
      bl_d       = bl_q - mf2d_pkg::SIDE_W'(1);
      bjob_d.col = bjob_q.col + mf2d_pkg::COL_W'(1);
    end
    if (acc) begin
      bl_d        = emits ? nj : '0;
      bjob_d.row  = mf2d_pkg::ROW_W'(eir - mf2d_pkg::DIM_W'(cfg_i.half));
      bjob_d.col  = c0;
      bjob_d.irow = eir;
      bjob_d.prow = pr;
      if (icn == {1'b0, cfg_i.width}) begin
        ic_d = '0;
        if ({1'b0, irn} == hk) begin
          ir_d = '0;
          p_d  = '0;
        end else begin
          ir_d = irn;
          p_d  = (ep == mf2d_pkg::PHYS_W'(mf2d_pkg::STORE_ROWS - 1)) ? '0
                 : ep + mf2d_pkg::PHYS_W'(1);
        end
      end else begin
        ic_d = mf2d_pkg::COL_W'(icn);
        ir_d = eir;
        p_d  = ep;
      end
    end
    if (restart_i) begin
      ir_d = '0;
      ic_d = '0;
      p_d  = '0;
      bl_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ir_q <= '0;
      ic_q <= '0;
      p_q  <= '0;
      bl_q <= '0;
    end else begin
      ir_q <= ir_d;
      ic_q <= ic_d;
      p_q  <= p_d;
      bl_q <= bl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bjob_q <= bjob_d;
  end

endmodule

[rtl/mf2d_back.sv]
// Back part: gathers the reflected window from the line store and finds its
// median one bit per cycle, then holds the result in an output register.
// Depends on mf2d_pkg.
module mf2d_back (
  input  logic                                                         clk_i,
  input  logic                                                         rst_ni,
  input  mf2d_pkg::cfg_t                                               cfg_i,
  input  logic                                                         q_empty_i,
  input  mf2d_pkg::job_t                                               q_job_i,
  output logic                                                         pop_o,
  output logic [mf2d_pkg::COL_W-1:0]                                   raddr_o,
  input  logic [mf2d_pkg::STORE_ROWS-1:0][mf2d_pkg::PIXEL_BITS-1:0]    rdata_i,
  output logic                                                         busy_o,
  output mf2d_pkg::job_t                                               job_o,
  output logic                                                         out_valid_o,
  output mf2d_pkg::out_item_t                                          out_data_o,
  input  logic                                                         out_stall_i
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_READ = 2'd1;
  localparam logic [1:0] ST_SEL  = 2'd2;
  localparam logic [1:0] ST_OUT  = 2'd3;
  localparam int SW = mf2d_pkg::DIM_W + 2;

  logic [1:0]                     st_q, st_d;
  mf2d_pkg::job_t                 job_q, job_d;
  logic [mf2d_pkg::SIDE_W-1:0]    j_q, j_d, cj_q, cj_d, side_m1, side;
  logic                           cap_q, cap_d;
  logic [mf2d_pkg::PIXEL_BITS-1:0] win_q [mf2d_pkg::WIN_N];
  logic [mf2d_pkg::WIN_N-1:0]     cand_q, cand_d, mask, plane, zmask;
  logic [mf2d_pkg::RANK_W-1:0]    rank_q, rank_d, cnt0;
  logic [mf2d_pkg::BIT_W-1:0]     bpos_q, bpos_d;
  logic [mf2d_pkg::PIXEL_BITS-1:0] med_q, med_d;
  logic                           ovld_q, ovld_d;
  mf2d_pkg::out_item_t            out_q, out_d;
  logic [mf2d_pkg::PHYS_W-1:0]    phys [mf2d_pkg::STORE_ROWS];
  logic                           last_c;

  assign side_m1 = {cfg_i.half, 1'b0};
  assign side    = {cfg_i.half, 1'b1};
  assign busy_o  = st_q != ST_IDLE;
  assign job_o   = job_q;
  assign out_valid_o = ovld_q;
  assign out_data_o  = out_q;

  // Mirrored column of the current read.
  always_comb begin
    logic signed [SW-1:0] t, wd;
    t  = $signed(SW'(job_q.col)) - $signed(SW'(cfg_i.half)) + $signed(SW'(j_q));
    wd = $signed(SW'(cfg_i.width));
    if (t < 0) begin
      t = -t - SW'(1);
    end else if (t >= wd) begin
      t = (wd <<< 1) - t - SW'(1);
    end
    raddr_o = mf2d_pkg::COL_W'(t);
  end

  // Store row of each window row, from the center row's store row and the
  // offset that mirroring at the top or bottom edge gives.
  always_comb begin
    logic signed [SW-1:0] t, rr, s, hd, rd;
    hd = $signed(SW'(cfg_i.height));
    rd = $signed(SW'(job_q.row));
    for (int i = 0; i < mf2d_pkg::STORE_ROWS; i++) begin
      t = rd + SW'(i) - $signed(SW'(cfg_i.half));
      if (t < 0) begin
        rr = -t - SW'(1);
      end else if (t >= hd) begin
        rr = (hd <<< 1) - t - SW'(1);
      end else begin
        rr = t;
      end
      s = $signed(SW'(job_q.prow)) + rr - rd;
      if (s < 0) begin
        s = s + SW'(mf2d_pkg::STORE_ROWS);
      end else if (s >= SW'(mf2d_pkg::STORE_ROWS)) begin
        s = s - SW'(mf2d_pkg::STORE_ROWS);
      end
      phys[i] = mf2d_pkg::PHYS_W'(s);
    end
  end

  always_comb begin
    for (int i = 0; i < mf2d_pkg::STORE_ROWS; i++) begin
      for (int j = 0; j < mf2d_pkg::STORE_ROWS; j++) begin
        mask[i*mf2d_pkg::STORE_ROWS+j] = (mf2d_pkg::SIDE_W'(i) <= side_m1)
                                         && (mf2d_pkg::SIDE_W'(j) <= side_m1);
      end
    end
  end

  always_comb begin
    for (int n = 0; n < mf2d_pkg::WIN_N; n++) begin
      plane[n] = win_q[n][bpos_q];
    end
    zmask = cand_q & ~plane;
    cnt0  = '0;
    for (int n = 0; n < mf2d_pkg::WIN_N; n++) begin
      cnt0 = cnt0 + mf2d_pkg::RANK_W'(zmask[n]);
    end
  end

  assign last_c = {1'b0, job_q.col} == (cfg_i.width - mf2d_pkg::DIM_W'(1));

  always_comb begin
    st_d   = st_q;
    job_d  = job_q;
    j_d    = j_q;
    cj_d   = cj_q;
    cap_d  = 1'b0;
    cand_d = cand_q;
    rank_d = rank_q;
    bpos_d = bpos_q;
    med_d  = med_q;
    out_d  = out_q;
    ovld_d = ovld_q && out_stall_i;
    pop_o  = 1'b0;
    case (st_q)
      ST_IDLE: begin
        if (!q_empty_i) begin
          pop_o = 1'b1;
          job_d = q_job_i;
          j_d   = '0;
          st_d  = ST_READ;
        end
      end
      ST_READ: begin
        j_d = j_q + mf2d_pkg::SIDE_W'(1);
        if (j_q <= side_m1) begin
          cap_d = 1'b1;
          cj_d  = j_q;
        end
        if (j_q == side) begin
          cand_d = mask;
          rank_d = mf2d_pkg::half_rank(cfg_i.half);
          bpos_d = mf2d_pkg::BIT_W'(mf2d_pkg::PIXEL_BITS - 1);
          st_d   = ST_SEL;
        end
      end
      ST_SEL: begin
        if (rank_q < cnt0) begin
          med_d[bpos_q] = 1'b0;
          cand_d        = zmask;
        end else begin
          med_d[bpos_q] = 1'b1;
          cand_d        = cand_q & plane;
          rank_d        = rank_q - cnt0;
        end
        if (bpos_q == '0) begin
          st_d = ST_OUT;
        end else begin
          bpos_d = bpos_q - mf2d_pkg::BIT_W'(1);
        end
      end
      ST_OUT: begin
        if (!ovld_q || !out_stall_i) begin
          out_d.median        = med_q;
          out_d.last_in_row   = last_c;
          out_d.last_in_frame = last_c
              && ({1'b0, job_q.row} == (cfg_i.height - mf2d_pkg::DIM_W'(1)));
          ovld_d = 1'b1;
          st_d   = ST_IDLE;
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= ST_IDLE;
      cap_q  <= 1'b0;
      ovld_q <= 1'b0;
    end else begin
      st_q   <= st_d;
      cap_q  <= cap_d;
      ovld_q <= ovld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q  <= job_d;
    j_q    <= j_d;
    cj_q   <= cj_d;
    cand_q <= cand_d;
    rank_q <= rank_d;
    bpos_q <= bpos_d;
    med_q  <= med_d;
    out_q  <= out_d;
    if (cap_q) begin
      for (int i = 0; i < mf2d_pkg::STORE_ROWS; i++) begin
        win_q[mf2d_pkg::RANK_W'(i*mf2d_pkg::STORE_ROWS) + mf2d_pkg::RANK_W'(cj_q)]
          <= rdata_i[phys[i]];
      end
    end
  end

endmodule

[rtl/median_filter_2d_reflect_top.sv]
// Top level of the streaming 2-D median filter with mirrored frame edges.
// Depends on mf2d_pkg, mf2d_front, mf2d_queue, mf2d_back and mf2d_ram.
//
//   Channel  | Handshake                  | Payload
//   ---------+----------------------------+-----------------------------------
//   input    | in_valid_i / in_stall_o    | in_data_i  (cmd, pixel)
//   output   | out_valid_o / out_stall_i  | out_data_o (median, last flags)
//   config   | psel/penable/pwrite/pready | paddr, pwdata, prdata
//
// Each result passes through the back part in order (k is the window radius):
// it takes a job, reads window columns from the seven line store RAMs, runs
// the bit-serial median select and loads the output register. The back part
// takes no new job until it is done with the last; that loop sets the sustained
// rate. The front takes one input beat per cycle while it has no jobs left to
// post and no store hazard; a row-end beat posts k+1 jobs. A beat that starts
// a new store row waits until jobs of the previous row have left the back part.
// Reset clears all control state; the line store is not cleared.
module median_filter_2d_reflect_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  input  mf2d_pkg::in_item_t              in_data_i,
  output logic                            in_stall_o,
  output logic                            out_valid_o,
  output mf2d_pkg::out_item_t             out_data_o,
  input  logic                            out_stall_i,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [mf2d_pkg::ADDR_W-1:0]     paddr,
  input  logic [mf2d_pkg::DATA_W-1:0]     pwdata,
  output logic [mf2d_pkg::DATA_W-1:0]     prdata,
  output logic                            pready
);

  logic [mf2d_pkg::DIM_W-1:0]  width_q, height_q;
  logic [mf2d_pkg::HALF_W-1:0] half_q;
  logic                        cfg_wr;
  mf2d_pkg::cfg_t              cfg;

  // Register file. Any write restarts the frame position counters.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= mf2d_pkg::DIM_W'(512);
      height_q <= mf2d_pkg::DIM_W'(512);
      half_q   <= mf2d_pkg::HALF_W'(2);
    end else if (cfg_wr) begin
      case (paddr[3:2])
        mf2d_pkg::REG_IMAGE_WIDTH:  width_q  <= pwdata[mf2d_pkg::DIM_W-1:0];
        mf2d_pkg::REG_IMAGE_HEIGHT: height_q <= pwdata[mf2d_pkg::DIM_W-1:0];
        mf2d_pkg::REG_KERNEL_HALF:  half_q   <= pwdata[mf2d_pkg::HALF_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      mf2d_pkg::REG_IMAGE_WIDTH:  prdata = mf2d_pkg::DATA_W'(width_q);
      mf2d_pkg::REG_IMAGE_HEIGHT: prdata = mf2d_pkg::DATA_W'(height_q);
      mf2d_pkg::REG_KERNEL_HALF:  prdata = mf2d_pkg::DATA_W'(half_q);
      default:                    prdata = '0;
    endcase
  end

  // Out-of-range settings are clamped to the supported frame sizes and radius.
  always_comb begin
    cfg.width = width_q;
    if (width_q < mf2d_pkg::DIM_W'(mf2d_pkg::MIN_SIZE)) begin
      cfg.width = mf2d_pkg::DIM_W'(mf2d_pkg::MIN_SIZE);
    end else if (width_q > mf2d_pkg::DIM_W'(mf2d_pkg::MAX_WIDTH)) begin
      cfg.width = mf2d_pkg::DIM_W'(mf2d_pkg::MAX_WIDTH);
    end
    cfg.height = height_q;
    if (height_q < mf2d_pkg::DIM_W'(mf2d_pkg::MIN_SIZE)) begin
      cfg.height = mf2d_pkg::DIM_W'(mf2d_pkg::MIN_SIZE);
    end else if (height_q > mf2d_pkg::DIM_W'(mf2d_pkg::HEIGHT_CAP)) begin
      cfg.height = mf2d_pkg::DIM_W'(mf2d_pkg::HEIGHT_CAP);
    end
    cfg.half = (half_q == '0) ? mf2d_pkg::HALF_W'(1) : half_q;
  end

  mf2d_pkg::wr_t                         wr;
  logic                                  push, pop, q_full, q_empty, bk_busy;
  mf2d_pkg::job_t                        push_job, q_job, bk_job;
  mf2d_pkg::job_t [mf2d_pkg::QDEPTH-1:0] q_ent;
  logic [mf2d_pkg::QDEPTH-1:0]           q_vld;
  logic [mf2d_pkg::COL_W-1:0]            raddr;
  logic [mf2d_pkg::STORE_ROWS-1:0][mf2d_pkg::PIXEL_BITS-1:0] rdata;

  mf2d_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .restart_i  (cfg_wr),
    .in_valid_i (in_valid_i),
    .in_data_i  (in_data_i),
    .in_stall_o (in_stall_o),
    .wr_o       (wr),
    .push_o     (push),
    .job_o      (push_job),
    .q_full_i   (q_full),
    .q_ent_i    (q_ent),
    .q_vld_i    (q_vld),
    .bk_busy_i  (bk_busy),
    .bk_job_i   (bk_job)
  );

  mf2d_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .pop_i   (pop),
    .job_o   (q_job),
    .full_o  (q_full),
    .empty_o (q_empty),
    .ent_o   (q_ent),
    .vld_o   (q_vld)
  );

  // One RAM per store row, so all rows of a window column are read together.
  for (genvar g = 0; g < mf2d_pkg::STORE_ROWS; g++) begin : g_row
    mf2d_ram #(
      .WIDTH (mf2d_pkg::PIXEL_BITS),
      .DEPTH (mf2d_pkg::MAX_WIDTH)
    ) u_ram (
      .clk_i   (clk_i),
      .we_i    (wr.we && (wr.row == mf2d_pkg::PHYS_W'(g))),
      .waddr_i (wr.col),
      .wdata_i (wr.data),
      .raddr_i (raddr),
      .rdata_o (rdata[g])
    );
  end

  mf2d_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .q_empty_i   (q_empty),
    .q_job_i     (q_job),
    .pop_o       (pop),
    .raddr_o     (raddr),
    .rdata_i     (rdata),
    .busy_o      (bk_busy),
    .job_o       (bk_job),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .out_stall_i (out_stall_i)
  );

endmodule

[rtl/mf2d_checker.sv]
// Port-level checks of the median filter top level, bound to every instance.
// Depends on mf2d_pkg and median_filter_2d_reflect_top.
module mf2d_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        out_valid_o,
  input mf2d_pkg::out_item_t         out_data_o,
  input logic                        out_stall_i,
  input logic                        psel,
  input logic                        penable,
  input logic                        pready
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_data_o))
    else $error("result beat changed while stalled");

  a_frame_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.last_in_frame |-> out_data_o.last_in_row)
    else $error("frame end flagged away from a row end");

  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel && penable |-> pready)
    else $error("register access not completed");

endmodule

bind median_filter_2d_reflect_top mf2d_checker u_mf2d_checker (.*);
